// ===== sv/tht_pkg.sv =====
// ----------------------------------------------------------------------------
// tht_pkg
// Shared constants, opcodes, slot entry type and handle helpers for the
// typed handle table.
// ----------------------------------------------------------------------------
package tht_pkg;

  localparam int unsigned MAX_SLOTS        = 64;
  localparam int unsigned SLOT_W           = $clog2(MAX_SLOTS);
  localparam int unsigned FIRST_ALLOC_SLOT = 3;
  localparam int unsigned TYPE_SHIFT       = 32;
  localparam int unsigned TYPE_W           = 3;
  localparam int unsigned MAX_TYPE_CODE    = 7;
  localparam int unsigned FILE_TYPE_CODE   = 1;
  localparam logic [31:0] DUP_RIGHT_MASK   = 32'h0000_0001;
  localparam logic [63:0] NO_HANDLE        = '1;

  typedef enum logic [3:0] {
    OP_ALLOC        = 4'd0,
    OP_ALLOC_AT     = 4'd1,
    OP_CLOSE        = 4'd2,
    OP_CLOSE_TYPED  = 4'd3,
    OP_LOOKUP       = 4'd4,
    OP_DUP          = 4'd5,
    OP_DUP_TYPED    = 4'd6,
    OP_DUP_TO       = 4'd7,
    OP_DUP_TO_TYPED = 4'd8,
    OP_GET_COE      = 4'd9,
    OP_SET_COE      = 4'd10,
    OP_COE_SWEEP    = 4'd11,
    OP_CLOSE_ALL    = 4'd12
  } op_e;

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [31:0]       rights;
    logic [31:0]       obj;
    logic              ret;
    logic              rel;
    logic              coe;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  typedef struct packed {
    logic              ok;
    logic [TYPE_W-1:0] typ;
    logic [SLOT_W-1:0] slot;
  } dec_t;

  function automatic dec_t decode(input logic [63:0] h);
    logic [63:0] rt;
    logic [63:0] rs;
    logic [63:0] min_s;
    dec_t        d;
    rt    = h >> TYPE_SHIFT;
    rs    = h & ((64'd1 << TYPE_SHIFT) - 64'd1);
    min_s = (rt == 64'(FILE_TYPE_CODE)) ? 64'd0 : 64'(FIRST_ALLOC_SLOT);
    d.ok  = (rt != 64'd0) && (rt <= 64'(MAX_TYPE_CODE)) &&
            (rs < 64'(MAX_SLOTS)) && (rs >= min_s);
    d.typ  = rt[TYPE_W-1:0];
    d.slot = rs[SLOT_W-1:0];
    return d;
  endfunction

  function automatic logic [63:0] make_handle(input logic [TYPE_W-1:0] t,
                                              input logic [SLOT_W-1:0] s);
    return (64'(t) << TYPE_SHIFT) | 64'(s);
  endfunction

endpackage

// ===== sv/tht_ram.sv =====
// ----------------------------------------------------------------------------
// tht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/typed_handle_table.sv =====
// ----------------------------------------------------------------------------
// typed_handle_table
// Table of typed handle slots with allocate, close, lookup, duplicate,
// close-on-exec and sweep requests.
//
// Usage: a request is taken on in_valid_i/in_ready_o; results leave on
// out_valid_o/out_ready_i, with last_o on the final result of the request.
// One request is in flight at a time; in_ready_o is low from acceptance
// until the last result has been taken.
// Duplicate-to reads source and target in turn from the one read port of
// the slot RAM. Sweeps visit one slot per read, over every slot of the table.
// Sweeps give one result per release event, or one empty result.
// Reset marks every slot empty at once through per-slot occupancy flags;
// no clearing pass is needed and the block is ready right after reset.
// A stalled receiver holds the result register and the sequencer.
// ----------------------------------------------------------------------------
module typed_handle_table
  import tht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  operation_i,
  input  logic [63:0] handle_i,
  input  logic [63:0] second_handle_i,
  input  logic [2:0]  handle_type_i,
  input  logic [31:0] rights_i,
  input  logic [31:0] object_id_i,
  input  logic        has_retain_i,
  input  logic        has_release_i,
  input  logic        close_on_exec_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [63:0] result_handle_o,
  output logic [31:0] found_object_o,
  output logic        coe_value_o,
  output logic        retain_valid_o,
  output logic [31:0] retain_object_o,
  output logic        release_valid_o,
  output logic [31:0] release_object_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_EV1, S_RD2, S_EV2, S_ALLOC,
    S_SW_RD, S_SW_EV, S_SW_NEXT, S_SW_FIN, S_OUT
  } state_e;

  state_e              state_q;
  op_e                 op_q;
  logic [63:0]         h_q, h2_q;
  logic [TYPE_W-1:0]   ty_q;
  logic [31:0]         rights_q, obj_q;
  logic                ret_q, rel_q, coe_q;
  logic [MAX_SLOTS-1:0] occ_q;
  ent_t                src_q;
  logic [SLOT_W-1:0]   idx_q, rd_slot_q;
  logic                pv_q;
  logic [31:0]         po_q;

  logic                out_valid_q, status_q, coev_q, rv_q, lv_q, last_q;
  logic [63:0]         rh_q;
  logic [31:0]         found_q, ro_q, lo_q;

  logic                we_q;
  logic [SLOT_W-1:0]   waddr_q;
  ent_t                wdata_q;

  logic [SLOT_W-1:0]   raddr;
  logic [ENT_W-1:0]    rdata;
  ent_t                rd_ent;
  dec_t                dec1, dec2;
  logic                free_ok;
  logic [SLOT_W-1:0]   free_slot;
  logic                get_ok;
  logic                out_fire;

  tht_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    dec1 = decode(h_q);
    dec2 = decode(h2_q);
    case (state_q)
      S_RD2:   raddr = dec2.slot;
      S_SW_RD: raddr = idx_q;
      default: raddr = dec1.slot;
    endcase
    rd_ent = occ_q[rd_slot_q] ? ent_t'(rdata) : '0;
    get_ok = dec1.ok && (rd_ent.typ != '0) && (rd_ent.typ == dec1.typ);
    free_ok   = 1'b0;
    free_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= int'(FIRST_ALLOC_SLOT); i--) begin
      if (!occ_q[i]) begin
        free_ok   = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign out_fire   = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      we_q        <= 1'b0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
    end else begin
      we_q      <= 1'b0;
      rd_slot_q <= raddr;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= op_e'(operation_i);
            h_q      <= handle_i;
            h2_q     <= second_handle_i;
            ty_q     <= handle_type_i;
            rights_q <= rights_i;
            obj_q    <= object_id_i;
            ret_q    <= has_retain_i;
            rel_q    <= has_release_i;
            coe_q    <= close_on_exec_i;
            status_q <= 1'b1;
            rh_q     <= NO_HANDLE;
            found_q  <= '0;
            coev_q   <= 1'b0;
            rv_q     <= 1'b0;
            ro_q     <= '0;
            lv_q     <= 1'b0;
            lo_q     <= '0;
            last_q   <= 1'b1;
            idx_q    <= '0;
            pv_q     <= 1'b0;
            po_q     <= '0;
            case (op_e'(operation_i))
              OP_ALLOC: state_q <= S_ALLOC;
              OP_ALLOC_AT, OP_CLOSE, OP_CLOSE_TYPED, OP_LOOKUP, OP_DUP,
              OP_DUP_TYPED, OP_DUP_TO, OP_DUP_TO_TYPED, OP_GET_COE,
              OP_SET_COE: state_q <= S_RD1;
              OP_COE_SWEEP, OP_CLOSE_ALL: begin
                status_q <= 1'b0;
                state_q  <= S_SW_RD;
              end
              default: begin
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (ty_q != '0 && obj_q != '0 && free_ok) begin
            occ_q[free_slot] <= 1'b1;
            we_q     <= 1'b1;
            waddr_q  <= free_slot;
            wdata_q  <= '{typ: ty_q, rights: rights_q, obj: obj_q,
                          ret: ret_q, rel: rel_q, coe: coe_q};
            rh_q     <= make_handle(ty_q, free_slot);
            status_q <= 1'b0;
          end
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_RD1: state_q <= S_EV1;
        S_EV1: begin
          src_q       <= rd_ent;
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
          case (op_q)
            OP_ALLOC_AT: begin
              if (dec1.ok && dec1.typ == ty_q && obj_q != '0) begin
                if (rd_ent.typ == dec1.typ && rd_ent.rel && rd_ent.obj != '0) begin
                  lv_q <= 1'b1;
                  lo_q <= rd_ent.obj;
                end
                occ_q[dec1.slot] <= 1'b1;
                we_q     <= 1'b1;
                waddr_q  <= dec1.slot;
                wdata_q  <= '{typ: ty_q, rights: rights_q, obj: obj_q,
                              ret: ret_q, rel: rel_q, coe: coe_q};
                rh_q     <= h_q;
                status_q <= 1'b0;
              end
            end
            OP_CLOSE, OP_CLOSE_TYPED: begin
              if (get_ok && (op_q == OP_CLOSE || rd_ent.typ == ty_q)) begin
                if (rd_ent.rel && rd_ent.obj != '0) begin
                  lv_q <= 1'b1;
                  lo_q <= rd_ent.obj;
                end
                occ_q[dec1.slot] <= 1'b0;
                status_q <= 1'b0;
              end
            end
            OP_LOOKUP: begin
              if (get_ok && rd_ent.typ == ty_q &&
                  (rd_ent.rights & rights_q) == rights_q) begin
                found_q  <= rd_ent.obj;
                status_q <= 1'b0;
              end
            end
            OP_DUP, OP_DUP_TYPED: begin
              if (get_ok && (op_q == OP_DUP || rd_ent.typ == ty_q) &&
                  (rd_ent.rights & DUP_RIGHT_MASK) != '0) begin
                if (rd_ent.ret) begin
                  rv_q <= 1'b1;
                  ro_q <= rd_ent.obj;
                end
                if (free_ok) begin
                  occ_q[free_slot] <= 1'b1;
                  we_q     <= 1'b1;
                  waddr_q  <= free_slot;
                  wdata_q  <= '{typ: rd_ent.typ, rights: rd_ent.rights,
                                obj: rd_ent.obj, ret: rd_ent.ret,
                                rel: rd_ent.rel, coe: 1'b0};
                  rh_q     <= make_handle(rd_ent.typ, free_slot);
                  status_q <= 1'b0;
                end else if (rd_ent.rel) begin
                  lv_q <= 1'b1;
                  lo_q <= rd_ent.obj;
                end
              end
            end
            OP_DUP_TO, OP_DUP_TO_TYPED: begin
              if (get_ok && (op_q == OP_DUP_TO || rd_ent.typ == ty_q) &&
                  (rd_ent.rights & DUP_RIGHT_MASK) != '0) begin
                if (h_q == h2_q) begin
                  rh_q     <= h2_q;
                  status_q <= 1'b0;
                end else if (dec2.ok && dec2.typ == rd_ent.typ) begin
                  out_valid_q <= 1'b0;
                  state_q     <= S_RD2;
                end
              end
            end
            OP_GET_COE: begin
              if (get_ok) begin
                coev_q   <= rd_ent.coe;
                status_q <= 1'b0;
              end
            end
            OP_SET_COE: begin
              if (get_ok) begin
                we_q     <= 1'b1;
                waddr_q  <= dec1.slot;
                wdata_q  <= '{typ: rd_ent.typ, rights: rd_ent.rights,
                              obj: rd_ent.obj, ret: rd_ent.ret,
                              rel: rd_ent.rel, coe: coe_q};
                status_q <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_RD2: state_q <= S_EV2;
        S_EV2: begin
          if (op_q != OP_DUP_TO_TYPED || rd_ent.typ == '0 || rd_ent.typ == ty_q) begin
            if (src_q.ret) begin
              rv_q <= 1'b1;
              ro_q <= src_q.obj;
            end
            if (rd_ent.typ == dec2.typ && rd_ent.rel && rd_ent.obj != '0) begin
              lv_q <= 1'b1;
              lo_q <= rd_ent.obj;
            end
            occ_q[dec2.slot] <= 1'b1;
            we_q     <= 1'b1;
            waddr_q  <= dec2.slot;
            wdata_q  <= '{typ: src_q.typ, rights: src_q.rights, obj: src_q.obj,
                          ret: src_q.ret, rel: src_q.rel, coe: 1'b0};
            rh_q     <= h2_q;
            status_q <= 1'b0;
          end
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_SW_RD: state_q <= S_SW_EV;
        S_SW_EV: begin
          state_q <= S_SW_NEXT;
          if (occ_q[idx_q] && (op_q == OP_CLOSE_ALL || rd_ent.coe)) begin
            occ_q[idx_q] <= 1'b0;
            if (rd_ent.rel && rd_ent.obj != '0) begin
              po_q <= rd_ent.obj;
              pv_q <= 1'b1;
              if (pv_q) begin
                lv_q        <= 1'b1;
                lo_q        <= po_q;
                last_q      <= 1'b0;
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
            end
          end
        end
        S_SW_NEXT: begin
          if (idx_q == SLOT_W'(MAX_SLOTS - 1)) begin
            state_q <= S_SW_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SW_RD;
          end
        end
        S_SW_FIN: begin
          lv_q        <= pv_q;
          lo_q        <= po_q;
          last_q      <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            out_valid_q <= 1'b0;
            state_q     <= last_q ? S_IDLE : S_SW_NEXT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign result_handle_o  = rh_q;
  assign found_object_o   = found_q;
  assign coe_value_o      = coev_q;
  assign retain_valid_o   = rv_q;
  assign retain_object_o  = ro_q;
  assign release_valid_o  = lv_q;
  assign release_object_o = lo_q;
  assign last_o           = last_q;

endmodule

// ===== sv/tht_checker.sv =====
// ----------------------------------------------------------------------------
// tht_checker
// Port-level checks for the typed handle table, bound to the top level.
// ----------------------------------------------------------------------------
module tht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_handle_o,
  input logic        release_valid_o,
  input logic [31:0] release_object_o,
  input logic        retain_valid_o,
  input logic [31:0] retain_object_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_handle_o)
      && $stable(last_o) && $stable(release_object_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a request was taken");

  a_idle_objects_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (release_valid_o || release_object_o == '0) &&
                    (retain_valid_o || retain_object_o == '0))
    else $error("object without event");

  a_nonlast_has_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> release_valid_o)
    else $error("non-final result without release");

endmodule

bind typed_handle_table tht_checker u_tht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_handle_o  (result_handle_o),
  .release_valid_o  (release_valid_o),
  .release_object_o (release_object_o),
  .retain_valid_o   (retain_valid_o),
  .retain_object_o  (retain_object_o),
  .last_o           (last_o)
);
